// ===== hdl/psrf_pkg.sv =====
package psrf_pkg;

    // interface to this many ports can carry a promiscuous or all-multicast bit
    localparam int NUM_IFACES = 8;
    localparam int MASK_W     = 8;
    localparam int MASK_IFACES = (NUM_IFACES < MASK_W) ? NUM_IFACES : MASK_W;

    localparam int MAC_W    = 48;
    localparam int IFX_W    = 4;
    localparam int ETYPE_W  = 16;
    localparam int LEN_W    = 16;
    localparam int CMD_W    = 2;
    localparam int CLASS_W  = 2;
    localparam int STRIP_W  = 5;
    localparam int STATUS_W = 2;

    localparam int IN_FIELDS_W = IFX_W + MAC_W + ETYPE_W + LEN_W + MAC_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + CLASS_W + STRIP_W + STATUS_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RECV_ENABLE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PROTO_FILTER  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BOUND_IFINDEX = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SOCKET_DGRAM  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PROMISC_MASK  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ALLMULTI_MASK = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_VLAN_TRIM     = 3'd6;

    // commands
    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DROP  = 2'd2;

    // packet classes
    localparam logic [CLASS_W-1:0] CLASS_HOST  = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_BCAST = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_MCAST = 2'd2;

    // membership status
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_MCAST = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    localparam logic [ETYPE_W-1:0] PROTO_ANY      = 16'h0003;
    localparam logic [ETYPE_W-1:0] ETYPE_VLAN_TAG = 16'h8100;
    localparam logic [IFX_W-1:0]   IFX_UNBOUND    = 4'd0;
    localparam logic [LEN_W-1:0]   ETH_HDR_LEN    = 16'd14;
    localparam logic [STRIP_W-1:0] STRIP_ETH      = 5'd14;
    localparam logic [STRIP_W-1:0] STRIP_ETH_VLAN = 5'd18;  // eth header plus vlan tag
    localparam int                 GROUP_BIT      = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [STRIP_W-1:0]  strip_bytes;
        logic [CLASS_W-1:0]  pkt_class;
        logic                deliver;
    } result_t;

endpackage

// ===== hdl/packet_socket_rx_filter.sv =====
// a request accepted into the input register moves on to the result register (m_tvalid)
// when that is empty or taken; throughput: one request per cycle while no result is held
// the membership table is a parallel compare of all entries
// a held result still lets one request into the input register, then s_tready drops
// reset: configuration returns to its defaults and the membership table is empty at once
module packet_socket_rx_filter #(
    parameter int MEMBER_ENTRIES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [psrf_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [psrf_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // ifindex, mac_addr, eth_type, frame_len, iface_mac, zero fill
    input  logic [psrf_pkg::IN_DATA_W-1:0]        s_tdata,
    // cmd
    input  logic [psrf_pkg::CMD_W-1:0]            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // deliver, pkt_class, strip_bytes, status, zero fill
    output logic [psrf_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import psrf_pkg::*;

    localparam int IFX_LO   = 0;
    localparam int MAC_LO   = IFX_LO + IFX_W;
    localparam int ETYPE_LO = MAC_LO + MAC_W;
    localparam int LEN_LO   = ETYPE_LO + ETYPE_W;
    localparam int OWN_LO   = LEN_LO + LEN_W;

    // configuration
    logic                recv_enable_reg;
    logic [ETYPE_W-1:0]  proto_filter_reg;
    logic [IFX_W-1:0]    bound_ifindex_reg;
    logic                socket_dgram_reg;
    logic [MASK_W-1:0]   promisc_mask_reg;
    logic [MASK_W-1:0]   allmulti_mask_reg;
    logic                vlan_trim_reg;

    // input register
    logic                s1_valid_reg;
    logic [CMD_W-1:0]    s1_cmd_reg;
    logic [IFX_W-1:0]    s1_ifx_reg;
    logic [MAC_W-1:0]    s1_mac_reg;
    logic [ETYPE_W-1:0]  s1_etype_reg;
    logic [LEN_W-1:0]    s1_len_reg;
    logic [MAC_W-1:0]    s1_own_reg;

    // membership table
    logic [MEMBER_ENTRIES-1:0] mem_valid_reg;
    logic [IFX_W-1:0]          mem_iface_reg [MEMBER_ENTRIES];
    logic [MAC_W-1:0]          mem_group_reg [MEMBER_ENTRIES];

    // result register
    logic                m_valid_reg;
    result_t             m_res_reg;

    logic                      advance;
    logic                      s_fire;
    logic [MEMBER_ENTRIES-1:0] hit;
    logic [MEMBER_ENTRIES-1:0] free_vec;
    logic [MEMBER_ENTRIES-1:0] first_free;
    logic                      any_hit;
    logic                      any_free;
    logic                      mcast;
    logic                      ifx_in_mask;
    logic [2:0]                ifx_bit;
    logic                      promisc_bit;
    logic                      allmulti_bit;
    logic                      frame_ok;
    logic                      add_wr;
    logic                      drop_wr;
    result_t                   res_next;

    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recv_enable_reg   <= 1'b0;
            proto_filter_reg  <= PROTO_ANY;
            bound_ifindex_reg <= IFX_UNBOUND;
            socket_dgram_reg  <= 1'b0;
            promisc_mask_reg  <= '0;
            allmulti_mask_reg <= '0;
            vlan_trim_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_RECV_ENABLE:   recv_enable_reg   <= cfg_wdata[0];
                REG_PROTO_FILTER:  proto_filter_reg  <= cfg_wdata[ETYPE_W-1:0];
                REG_BOUND_IFINDEX: bound_ifindex_reg <= cfg_wdata[IFX_W-1:0];
                REG_SOCKET_DGRAM:  socket_dgram_reg  <= cfg_wdata[0];
                REG_PROMISC_MASK:  promisc_mask_reg  <= cfg_wdata[MASK_W-1:0];
                REG_ALLMULTI_MASK: allmulti_mask_reg <= cfg_wdata[MASK_W-1:0];
                REG_VLAN_TRIM:     vlan_trim_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_cmd_reg   <= s_tuser;
            s1_ifx_reg   <= s_tdata[IFX_LO +: IFX_W];
            s1_mac_reg   <= s_tdata[MAC_LO +: MAC_W];
            s1_etype_reg <= s_tdata[ETYPE_LO +: ETYPE_W];
            s1_len_reg   <= s_tdata[LEN_LO +: LEN_W];
            s1_own_reg   <= s_tdata[OWN_LO +: MAC_W];
        end
    end

    always_comb
    begin
        for (int i = 0; i < MEMBER_ENTRIES; i++)
            hit[i] = mem_valid_reg[i] && (mem_iface_reg[i] == s1_ifx_reg)
                     && (mem_group_reg[i] == s1_mac_reg);
    end

    assign free_vec   = ~mem_valid_reg;
    assign first_free = free_vec & (~free_vec + MEMBER_ENTRIES'(1));  // lowest free entry
    assign any_hit    = |hit;
    assign any_free   = |free_vec;
    assign mcast      = s1_mac_reg[GROUP_BIT];

    assign ifx_in_mask  = (s1_ifx_reg != '0) && (s1_ifx_reg <= IFX_W'(MASK_IFACES));
    assign ifx_bit      = 3'(s1_ifx_reg - IFX_W'(1));
    assign promisc_bit  = ifx_in_mask && promisc_mask_reg[ifx_bit];
    assign allmulti_bit = ifx_in_mask && allmulti_mask_reg[ifx_bit];

    assign frame_ok = recv_enable_reg && (s1_len_reg > ETH_HDR_LEN)
                      && (proto_filter_reg == PROTO_ANY || proto_filter_reg == s1_etype_reg)
                      && (bound_ifindex_reg == IFX_UNBOUND
                          || bound_ifindex_reg == s1_ifx_reg)
                      && ((s1_mac_reg == s1_own_reg) || promisc_bit
                          || (mcast && (allmulti_bit || any_hit)));

    assign add_wr  = advance && (s1_cmd_reg == CMD_ADD) && mcast && !any_hit && any_free;
    assign drop_wr = advance && (s1_cmd_reg == CMD_DROP) && any_hit;

    always_comb
    begin
        res_next = '0;
        case (s1_cmd_reg)
            CMD_FRAME:
            begin
                if (frame_ok)
                begin
                    res_next.deliver = 1'b1;
                    if (!mcast)
                        res_next.pkt_class = CLASS_HOST;
                    else if (&s1_mac_reg)
                        res_next.pkt_class = CLASS_BCAST;
                    else
                        res_next.pkt_class = CLASS_MCAST;
                    if (socket_dgram_reg)
                        res_next.strip_bytes = (vlan_trim_reg && s1_etype_reg == ETYPE_VLAN_TAG)
                                               ? STRIP_ETH_VLAN : STRIP_ETH;
                end
            end
            CMD_ADD:
            begin
                if (!mcast)
                    res_next.status = ST_NOT_MCAST;
                else if (!any_hit && !any_free)
                    res_next.status = ST_FULL;
                else
                    res_next.status = ST_OK;
            end
            CMD_DROP: res_next.status = ST_OK;
            default:  res_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mem_valid_reg <= '0;
        else if (add_wr)
            mem_valid_reg <= mem_valid_reg | first_free;
        else if (drop_wr)
            mem_valid_reg <= mem_valid_reg & ~hit;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MEMBER_ENTRIES; i++)
        begin
            if (add_wr && first_free[i])
            begin
                mem_iface_reg[i] <= s1_ifx_reg;
                mem_group_reg[i] <= s1_mac_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (advance)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            m_res_reg <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), m_res_reg};

    // an (interface, group) pair is never stored twice
    assert property (@(posedge clk) disable iff (!rst_n) s1_valid_reg |-> $onehot0(hit))
        else $error("duplicate membership entry");

    // a taken add fills exactly one more entry
    assert property (@(posedge clk) disable iff (!rst_n)
        add_wr |=> $countones(mem_valid_reg) == $past($countones(mem_valid_reg)) + 1)
        else $error("add did not grow the table by one");

    // a drop of a present entry frees exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        drop_wr |=> $countones(mem_valid_reg) + 1 == $past($countones(mem_valid_reg)))
        else $error("drop did not shrink the table by one");

    // a full status only when no entry was free
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.status == ST_FULL |-> mem_valid_reg == '1)
        else $error("table full flagged with a free entry");

    // a delivered frame carries ok status and a legal strip count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_res_reg.deliver |-> m_res_reg.status == ST_OK
        && (m_res_reg.strip_bytes == '0 || m_res_reg.strip_bytes == STRIP_ETH
            || m_res_reg.strip_bytes == STRIP_ETH_VLAN))
        else $error("bad delivered result");

endmodule

// ===== tb/tb_packet_socket_rx_filter.sv =====
module tb_packet_socket_rx_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import psrf_pkg::*;

    localparam int TABLE_DEPTH   = 16;
    localparam int ITEMS_PER_SET = 220;
    localparam int NUM_SETS      = 8;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 4000;

    // command code that the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [IFX_W-1:0]   ifx;
        logic [MAC_W-1:0]   dst;
        logic [ETYPE_W-1:0] etype;
        logic [LEN_W-1:0]   flen;
        logic [MAC_W-1:0]   own;
    } request_t;

    typedef struct {
        logic               recv_en;
        logic [ETYPE_W-1:0] proto;
        logic [IFX_W-1:0]   bound;
        logic               dgram;
        logic [MASK_W-1:0]  promisc;
        logic [MASK_W-1:0]  allmulti;
        logic               vlan_trim;
    } filter_cfg_t;

    class filter_scoreboard;
        logic               recv_en;
        logic [ETYPE_W-1:0] proto;
        logic [IFX_W-1:0]   bound;
        logic               dgram;
        logic [MASK_W-1:0]  promisc;
        logic [MASK_W-1:0]  allmulti;
        logic               vlan_trim;
        logic               grp_valid [TABLE_DEPTH];
        logic [IFX_W-1:0]   grp_iface [TABLE_DEPTH];
        logic [MAC_W-1:0]   grp_addr  [TABLE_DEPTH];
        result_t            expected_results [$];
        int                 mismatches;

        function new();
            recv_en   = 1'b0;
            proto     = PROTO_ANY;
            bound     = IFX_UNBOUND;
            dgram     = 1'b0;
            promisc   = '0;
            allmulti  = '0;
            vlan_trim = 1'b1;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                grp_valid[i] = 1'b0;
                grp_iface[i] = '0;
                grp_addr[i]  = '0;
            end
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_RECV_ENABLE:   recv_en   = val[0];
                REG_PROTO_FILTER:  proto     = val[ETYPE_W-1:0];
                REG_BOUND_IFINDEX: bound     = val[IFX_W-1:0];
                REG_SOCKET_DGRAM:  dgram     = val[0];
                REG_PROMISC_MASK:  promisc   = val[MASK_W-1:0];
                REG_ALLMULTI_MASK: allmulti  = val[MASK_W-1:0];
                REG_VLAN_TRIM:     vlan_trim = val[0];
                default: ;
            endcase
        endfunction

        // interfaces 0 and above the mask width never carry a mask bit
        function bit mask_hit(logic [MASK_W-1:0] m, logic [IFX_W-1:0] ifx);
            if (ifx == IFX_UNBOUND || int'(ifx) > MASK_IFACES)
                return 1'b0;
            return m[int'(ifx) - 1];
        endfunction

        function int find_group(logic [IFX_W-1:0] ifx, logic [MAC_W-1:0] grp);
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (grp_valid[i] && grp_iface[i] == ifx && grp_addr[i] == grp)
                    return i;
            return -1;
        endfunction

        function void note_request(request_t r);
            result_t e;
            bit      pass;
            bit      mc;
            int      slot;
            e    = '0;
            mc   = r.dst[GROUP_BIT];
            slot = -1;
            case (r.cmd)
                CMD_FRAME:
                begin
                    pass = recv_en && (r.flen > ETH_HDR_LEN)
                        && (proto == PROTO_ANY || proto == r.etype)
                        && (bound == IFX_UNBOUND || bound == r.ifx);
                    pass = pass && (r.dst == r.own || mask_hit(promisc, r.ifx)
                        || (mc && (mask_hit(allmulti, r.ifx) || find_group(r.ifx, r.dst) >= 0)));
                    if (pass)
                    begin
                        e.deliver = 1'b1;
                        if (!mc)
                            e.pkt_class = CLASS_HOST;
                        else if (&r.dst)
                            e.pkt_class = CLASS_BCAST;
                        else
                            e.pkt_class = CLASS_MCAST;
                        if (dgram)
                            e.strip_bytes = (vlan_trim && r.etype == ETYPE_VLAN_TAG) ?
                                            STRIP_ETH_VLAN : STRIP_ETH;
                    end
                end
                CMD_ADD:
                begin
                    if (!mc)
                        e.status = ST_NOT_MCAST;
                    else if (find_group(r.ifx, r.dst) < 0)
                    begin
                        // lowest free entry
                        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                            if (!grp_valid[i])
                                slot = i;
                        if (slot < 0)
                            e.status = ST_FULL;
                        else
                        begin
                            grp_valid[slot] = 1'b1;
                            grp_iface[slot] = r.ifx;
                            grp_addr[slot]  = r.dst;
                        end
                    end
                end
                CMD_DROP:
                begin
                    slot = find_group(r.ifx, r.dst);
                    if (slot >= 0)
                    begin
                        grp_valid[slot] = 1'b0;
                        grp_iface[slot] = '0;
                        grp_addr[slot]  = '0;
                    end
                end
                default: ;
            endcase
            expected_results = {expected_results, e};
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                mismatches++;
                return;
            end
            e = expected_results.pop_front();
            if (got.deliver !== e.deliver)
            begin
                $display("%0t: deliver expected %0d actual %0d", $time, e.deliver, got.deliver);
                mismatches++;
            end
            if (got.pkt_class !== e.pkt_class)
            begin
                $display("%0t: pkt_class expected %0d actual %0d", $time,
                         e.pkt_class, got.pkt_class);
                mismatches++;
            end
            if (got.strip_bytes !== e.strip_bytes)
            begin
                $display("%0t: strip_bytes expected %0d actual %0d", $time,
                         e.strip_bytes, got.strip_bytes);
                mismatches++;
            end
            if (got.status !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;

    filter_scoreboard sb;
    int send_idle_pct = 30;
    int recv_idle_pct = 85;
    int quiet_cycles = 0;

    packet_socket_rx_filter #(
        .MEMBER_ENTRIES(TABLE_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // result side: check, random backpressure, watchdog
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_result(result_t'(m_tdata[OUT_FIELDS_W-1:0]));
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_packet_socket_rx_filter failed");
            $finish;
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [MAC_W-1:0] own_mac(logic [IFX_W-1:0] ifx);
        return {8'h02, 8'h00, 8'h5E, 20'h00000, ifx};
    endfunction

    // small pool of group addresses so adds, drops and frames meet
    function automatic logic [MAC_W-1:0] pool_group(int k);
        case (k)
            0:       return 48'hFFFF_FFFF_FFFF;
            1:       return 48'h0100_5E00_0001;
            2:       return 48'h0100_5E7F_FFFA;
            3:       return 48'h3333_0000_0001;
            4:       return 48'hFF00_0000_0000;
            default: return 48'h0180_C200_000E;
        endcase
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom(), $urandom()});
    endfunction

    function automatic request_t req(logic [CMD_W-1:0] cmd, logic [IFX_W-1:0] ifx,
                                     logic [MAC_W-1:0] dst, logic [ETYPE_W-1:0] etype,
                                     logic [LEN_W-1:0] flen, logic [MAC_W-1:0] own);
        request_t r;
        r.cmd   = cmd;
        r.ifx   = ifx;
        r.dst   = dst;
        r.etype = etype;
        r.flen  = flen;
        r.own   = own;
        return r;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       pick;
        pick    = $urandom_range(99);
        r.cmd   = (pick < 55) ? CMD_FRAME : (pick < 80) ? CMD_ADD :
                  (pick < 95) ? CMD_DROP : CMD_UNUSED;
        r.ifx   = ($urandom_range(99) < 80) ? IFX_W'($urandom_range(1, 8))
                                            : IFX_W'($urandom_range(15));
        r.own   = ($urandom_range(9) == 0) ? rand_mac() : own_mac(r.ifx);
        r.etype = ETYPE_W'($urandom);
        r.flen  = LEN_W'($urandom);
        if (r.cmd == CMD_FRAME)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                r.etype = sb.proto;
            else if (pick < 60)
                r.etype = ETYPE_VLAN_TAG;
            pick = $urandom_range(99);
            if (pick < 10)
                r.flen = LEN_W'($urandom_range(14));
            else if (pick < 15)
                r.flen = LEN_W'(ETH_HDR_LEN + 1);
            else
                r.flen = LEN_W'($urandom_range(15, 65535));
            pick = $urandom_range(9);
            if (pick < 3)
                r.dst = r.own;
            else if (pick < 6)
                r.dst = pool_group($urandom_range(5));
            else if (pick == 6)
            begin
                r.dst = rand_mac();
                r.dst[GROUP_BIT] = 1'b0;
            end
            else if (pick == 7)
            begin
                r.dst = rand_mac();
                r.dst[GROUP_BIT] = 1'b1;
            end
            else
                r.dst = rand_mac();
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                r.dst = pool_group($urandom_range(5));
            else if (pick < 90)
            begin
                r.dst = rand_mac();
                r.dst[GROUP_BIT] = 1'b1;
            end
            else
                r.dst = rand_mac();
        end
        return r;
    endfunction

    function automatic filter_cfg_t filter_setting(int idx);
        filter_cfg_t c;
        case (idx)
            0: c = '{1'b1, PROTO_ANY, IFX_UNBOUND, 1'b1, 8'h00, 8'h00, 1'b1};
            1: c = '{1'b1, ETYPE_VLAN_TAG, 4'd8, 1'b1, 8'h00, 8'hFF, 1'b1};
            2: c = '{1'b0, 16'hFFFF, IFX_UNBOUND, 1'b0, 8'hFF, 8'hFF, 1'b0};
            3: c = '{1'b1, 16'h0000, 4'd1, 1'b1, 8'hFF, 8'h00, 1'b0};
            default:
            begin
                c.recv_en   = ($urandom_range(9) != 0);
                case ($urandom_range(3))
                    0:       c.proto = PROTO_ANY;
                    1:       c.proto = 16'h0800;
                    2:       c.proto = ETYPE_VLAN_TAG;
                    default: c.proto = ETYPE_W'($urandom);
                endcase
                c.bound     = ($urandom_range(1) == 0) ? IFX_UNBOUND
                                                       : IFX_W'($urandom_range(1, 8));
                c.dgram     = 1'($urandom_range(1));
                c.promisc   = ($urandom_range(2) == 0) ? 8'h00 : MASK_W'($urandom & $urandom);
                c.allmulti  = ($urandom_range(2) == 0) ? 8'h00 : MASK_W'($urandom & $urandom);
                c.vlan_trim = 1'($urandom_range(1));
            end
        endcase
        return c;
    endfunction

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // reprogram only once the block has drained
    task automatic apply_setting(filter_cfg_t c);
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_RECV_ENABLE, CFG_DATA_W'(c.recv_en));
        write_reg(REG_PROTO_FILTER, c.proto);
        write_reg(REG_BOUND_IFINDEX, CFG_DATA_W'(c.bound));
        write_reg(REG_SOCKET_DGRAM, CFG_DATA_W'(c.dgram));
        write_reg(REG_PROMISC_MASK, CFG_DATA_W'(c.promisc));
        write_reg(REG_ALLMULTI_MASK, CFG_DATA_W'(c.allmulti));
        write_reg(REG_VLAN_TRIM, CFG_DATA_W'(c.vlan_trim));
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, r.own, r.flen, r.etype, r.dst, r.ifx};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(r);
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_setting(filter_setting(0));
        send_request(req(CMD_FRAME, 4'd1, own_mac(4'd1), 16'h0800, LEN_W'(ETH_HDR_LEN + 1),
                         own_mac(4'd1)));
        send_request(req(CMD_FRAME, 4'd1, own_mac(4'd1), 16'h0800, ETH_HDR_LEN,
                         own_mac(4'd1)));
        send_request(req(CMD_FRAME, 4'd3, own_mac(4'd3), 16'h0800, 16'd0, own_mac(4'd3)));
        send_request(req(CMD_FRAME, 4'd8, own_mac(4'd8), ETYPE_VLAN_TAG, 16'hFFFF,
                         own_mac(4'd8)));
        // broadcast with no membership and no all-multicast is dropped
        send_request(req(CMD_FRAME, 4'd2, pool_group(0), 16'h0800, 16'd64, own_mac(4'd2)));
        // fill the table, interface indexes stored as given including 0 and above 8
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_request(req(CMD_ADD, IFX_W'(k), pool_group(k % 6), '0, '0, '0));
        send_request(req(CMD_ADD, 4'd1, pool_group(1), '0, '0, '0));
        send_request(req(CMD_ADD, 4'd1, pool_group(2), '0, '0, '0));
        send_request(req(CMD_FRAME, 4'd6, pool_group(0), 16'h0800, 16'd60, own_mac(4'd6)));
        send_request(req(CMD_FRAME, 4'd7, pool_group(1), 16'h0800, 16'd60, own_mac(4'd7)));
        send_request(req(CMD_FRAME, 4'd0, pool_group(0), 16'h0800, 16'd60, own_mac(4'd0)));
        send_request(req(CMD_ADD, 4'd2, own_mac(4'd2), '0, '0, '0));
        send_request(req(CMD_DROP, 4'd7, pool_group(1), '0, '0, '0));
        send_request(req(CMD_DROP, 4'd7, pool_group(1), '0, '0, '0));
        send_request(req(CMD_DROP, 4'd3, own_mac(4'd3), '0, '0, '0));
        send_request(req(CMD_UNUSED, 4'hF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF,
                         48'hFFFF_FFFF_FFFF));

        for (int p = 1; p <= NUM_SETS; p++)
        begin
            apply_setting(filter_setting(p));
            if (p <= 3)
            begin
                send_idle_pct = 30;
                recv_idle_pct = 85;
            end
            else if (p <= 6)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < ITEMS_PER_SET; n++)
                send_request(random_request());
        end

        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("tb_packet_socket_rx_filter passed");
        else
            $display("tb_packet_socket_rx_filter failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/psrf_pkg.sv
hdl/packet_socket_rx_filter.sv
tb/tb_packet_socket_rx_filter.sv
